// ===== hdl/lpds_pkg.sv =====
// shared types, constants and the ln table for the log potential direct sum
package lpds_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int VALUE_BITS_DEF = 32;
  localparam int QDEPTH_DEF = 4;
  localparam int CW = COORD_BITS_DEF;
  localparam int VW = VALUE_BITS_DEF;
  localparam int LN_TBL_BITS = 5;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic signed [CW-1:0] src_x;
    logic signed [CW-1:0] src_y;
    logic signed [VW-1:0] src_strength;
    logic signed [CW-1:0] tgt_x;
    logic signed [CW-1:0] tgt_y;
    logic                 last_source;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] potential;
    logic               saturated;
  } out_item_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic [CW:0]          ax;
    logic [CW:0]          ay;
    logic signed [VW-1:0] strength;
    logic                 last;
  } work_t;

  function automatic logic [23:0] ln_tbl(input logic [5:0] k);
    logic [23:0] v;
    unique case (k)
      6'd0: v = 24'd0;        6'd1: v = 24'd516263;   6'd2: v = 24'd1017112;
      6'd3: v = 24'd1503443;  6'd4: v = 24'd1976071;  6'd5: v = 24'd2435750;
      6'd6: v = 24'd2883169;  6'd7: v = 24'd3318965;  6'd8: v = 24'd3743728;
      6'd9: v = 24'd4158001;  6'd10: v = 24'd4562291; 6'd11: v = 24'd4957067;
      6'd12: v = 24'd5342767; 6'd13: v = 24'd5719799; 6'd14: v = 24'd6088544;
      6'd15: v = 24'd6449358; 6'd16: v = 24'd6802576; 6'd17: v = 24'd7148510;
      6'd18: v = 24'd7487455; 6'd19: v = 24'd7819688; 6'd20: v = 24'd8145469;
      6'd21: v = 24'd8465045; 6'd22: v = 24'd8778647; 6'd23: v = 24'd9086495;
      6'd24: v = 24'd9388795; 6'd25: v = 24'd9685745; 6'd26: v = 24'd9977530;
      6'd27: v = 24'd10264327; 6'd28: v = 24'd10546303; 6'd29: v = 24'd10823619;
      6'd30: v = 24'd11096425; 6'd31: v = 24'd11364866; 6'd32: v = 24'd11629080;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lpds_front.sv =====
// front end: takes sources, forms |dx| and |dy|, feeds a short queue
module lpds_front #(
  parameter int QDEPTH = lpds_pkg::QDEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lpds_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_take,
  output lpds_pkg::work_t   q_data
);
  localparam int AW = $clog2(QDEPTH);

  lpds_pkg::work_t mem [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic signed [lpds_pkg::CW:0] dx, dy;
  lpds_pkg::work_t w;
  logic do_push, do_pop;

  assign in_full = (cnt_r == (AW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign do_push = in_push && !in_full;
  assign do_pop  = q_take && q_valid;
  assign q_data  = mem[rp_r];

  always_comb begin
    dx = {in_data.tgt_x[lpds_pkg::CW-1], in_data.tgt_x}
       - {in_data.src_x[lpds_pkg::CW-1], in_data.src_x};
    dy = {in_data.tgt_y[lpds_pkg::CW-1], in_data.tgt_y}
       - {in_data.src_y[lpds_pkg::CW-1], in_data.src_y};
    w.ax = dx[lpds_pkg::CW] ? -dx : dx;
    w.ay = dy[lpds_pkg::CW] ? -dy : dy;
    w.strength = in_data.src_strength;
    w.last = in_data.last_source;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== hdl/lpds_back.sv =====
// back end: r2, ln by table and interpolation, multiply, saturating sum
module lpds_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_take,
  input  lpds_pkg::work_t q_data,
  output logic            out_empty,
  input  logic            out_pop,
  output lpds_pkg::out_item_t out_data
);
  localparam int CF = lpds_pkg::CW - 2;
  localparam int LF = lpds_pkg::VW - 8;
  localparam int SH = 32 - LF;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic go;
  // stage 1: squares
  logic [2*lpds_pkg::CW+1:0] sqx_r, sqy_r;
  // stage 2: r2
  logic [2*lpds_pkg::CW+2:0] r2_r;
  // stage 3: normalized mantissa and exponent
  logic [6:0] p3_r;
  logic [4:0] idx3_r;
  logic [23:0] fr3_r;
  // stage 4: ln
  logic signed [lpds_pkg::VW-1:0] ln4_r;
  logic signed [lpds_pkg::VW-1:0] st_r [1:4];
  logic lst_r [1:5];
  logic signed [63:0] term5_r;
  logic signed [63:0] acc_r;
  logic ovf_r;
  logic ob_valid_r, ob_valid_nxt;
  logic ob_load;
  lpds_pkg::out_item_t ob_r;

  // stall everything while an unread result waits and any item is in flight
  logic busy_last;
  assign busy_last = ob_valid_r && !out_pop;
  assign go = !(busy_last && (v1_r || v2_r || v3_r || v4_r || v5_r || q_valid));
  assign q_take = go && q_valid;
  assign out_empty = !ob_valid_r;
  assign out_data = ob_r;
  assign ob_load = go && v5_r && lst_r[5];

  always_comb begin
    ob_valid_nxt = ob_valid_r;
    if (out_pop && ob_valid_r) ob_valid_nxt = 1'b0;
    if (ob_load) ob_valid_nxt = 1'b1;
  end

  logic [2*lpds_pkg::CW+2:0] r2n;
  logic [6:0] pos;
  logic [63:0] norm;
  always_comb begin
    r2n = {1'b0, sqx_r} + {1'b0, sqy_r};
    // zero distance uses one lsb of r2
    if (r2n == '0) r2n = (2*lpds_pkg::CW+3)'(1);
    pos = '0;
    for (int i = 0; i <= 2*lpds_pkg::CW+2; i++) if (r2_r[i]) pos = 7'(i);
    norm = 64'(r2_r) << (7'd63 - pos);
  end

  logic [23:0] b0, b1, interp;
  logic [48:0] prod;
  logic signed [7:0] pexp;
  logic signed [47:0] q32;
  logic signed [47:0] lnq;
  always_comb begin
    b0 = lpds_pkg::ln_tbl({1'b0, idx3_r});
    b1 = lpds_pkg::ln_tbl(6'(idx3_r) + 6'd1);
    prod = 49'(b1 - b0) * 49'(fr3_r) + 49'(1 << 23);
    interp = b0 + prod[47:24];
    pexp = signed'({1'b0, p3_r}) - 8'(2*CF);
    q32 = 48'(pexp) * signed'({16'd0, lpds_pkg::LN2_Q32})
        + signed'(48'(interp) << 8);
    lnq = (q32 + 48'(1 << (SH-1))) >>> SH;
  end

  logic signed [64:0] sum;
  logic signed [63:0] acc_n;
  logic ovf_n;
  always_comb begin
    sum = 65'(acc_r) + 65'(term5_r);
    ovf_n = ovf_r;
    acc_n = sum[63:0];
    if (sum[64] != sum[63]) begin
      ovf_n = 1'b1;
      acc_n = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sqx_r <= q_data.ax * q_data.ax;
      sqy_r <= q_data.ay * q_data.ay;
      st_r[1] <= q_data.strength; lst_r[1] <= q_data.last;
      r2_r <= r2n; st_r[2] <= st_r[1]; lst_r[2] <= lst_r[1];
      p3_r <= pos; idx3_r <= norm[62:58]; fr3_r <= norm[57:34];
      st_r[3] <= st_r[2]; lst_r[3] <= lst_r[2];
      ln4_r <= lnq[lpds_pkg::VW-1:0]; st_r[4] <= st_r[3]; lst_r[4] <= lst_r[3];
      term5_r <= 64'(ln4_r) * 64'(st_r[4]); lst_r[5] <= lst_r[4];
    end
    if (ob_load) begin
      ob_r.potential <= acc_n >>> 1;
      ob_r.saturated <= ovf_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r} <= '0;
      acc_r <= '0;
      ovf_r <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      ob_valid_r <= ob_valid_nxt;
      if (go) begin
        v1_r <= q_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
        if (v5_r) begin
          if (lst_r[5]) begin
            acc_r <= '0;
            ovf_r <= 1'b0;
          end else begin
            acc_r <= acc_n;
            ovf_r <= ovf_n;
          end
        end
      end
    end
  end
endmodule

// ===== hdl/log_potential_direct_sum.sv =====
// top level: 2d log potential direct sum over a stream of sources
// One source per cycle enters a four-entry queue while it is not full; a
// six-stage back end (squares, r2, leading-one normalize, table ln,
// strength multiply, saturating accumulate) sustains one source per cycle
// unless stalled, and loads a run's result into its result register. The
// back end stalls only while its single result register is held unread.
module log_potential_direct_sum #(
  parameter int QDEPTH = lpds_pkg::QDEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  lpds_pkg::in_item_t   in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output lpds_pkg::out_item_t  out_data
);
  logic q_valid, q_take;
  lpds_pkg::work_t q_data;

  lpds_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data, .q_valid, .q_take, .q_data
  );
  lpds_back u_back (
    .clk, .rst_n, .q_valid, .q_take, .q_data, .out_empty, .out_pop, .out_data
  );
endmodule
